>>> rtl/fcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and codes of the allocation chain consistency checker.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam logic [1:0] KIND_LOAD_FAT = 2'd0;
    localparam logic [1:0] KIND_LOAD_DIR = 2'd1;
    localparam logic [1:0] KIND_RUN     = 2'd2;

    localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_FILE_COUNT = 2'd1;
    localparam logic [1:0] REG_FAT_COUNT  = 2'd2;

    typedef struct packed {
        logic signed [12:0] first;
        logic [30:0]        size;
    } dir_entry_t;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CLEAR  = 9'b000000010,
        ST_DIR_RD = 9'b000000100,
        ST_HEAD   = 9'b000001000,
        ST_ISSUE  = 9'b000010000,
        ST_VISIT  = 9'b000100000,
        ST_MUL    = 9'b001000000,
        ST_CMP    = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

endpackage
`default_nettype wire

>>> rtl/fcc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcc_ifs
// Request, result and register write channels of the checker.
// ----------------------------------------------------------------------------
interface fcc_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [11:0]        entry_index;
    logic signed [12:0] next_block;
    logic signed [12:0] first_block;
    logic [30:0]        file_size;
    modport source (output valid, kind, entry_index, next_block, first_block, file_size,
                    input ready);
    modport sink (input valid, kind, entry_index, next_block, first_block, file_size,
                  output ready);
endinterface

interface fcc_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  file_index;
    logic        too_few;
    logic        too_many;
    logic        has_cycle;
    logic        shares_blocks;
    logic [12:0] free_blocks;
    logic        is_summary;
    logic        last;
    modport source (output valid, file_index, too_few, too_many, has_cycle, shares_blocks,
                    free_blocks, is_summary, last, input ready);
    modport sink (input valid, file_index, too_few, too_many, has_cycle, shares_blocks,
                  free_blocks, is_summary, last, output ready);
endinterface

interface fcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/fat_chain_consistency_check_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fat_chain_consistency_check_unit
// Loads an allocation table and a directory, then walks every file's chain
// and reports per-file consistency flags followed by a free block count.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  item     | in        | load table entry, load directory entry, run request
//  result   | out       | per-file flags, then one summary with free count
//  cfg      | in        | block_size, file_count, fat_count register writes
//
// Load requests are written to memory as they are taken. A run request first
// clears the owner and visit tags of blocks 0 to fat_count-1, with fat_count
// capped at FAT_DEPTH, then for each file fetches its directory entry, visits
// each block of its chain (table and tag memory read, then tag write-back),
// runs the size check of a walked chain, and emits one result per file and the
// summary as the sink takes them.
// Reset is asynchronous; memory contents are not reset. A stalled result holds
// the block in its emit phase; requests are taken only while idle.
// ----------------------------------------------------------------------------
module fat_chain_consistency_check_unit
    import fcc_pkg::*;
#(
    parameter int FAT_DEPTH = 4096,
    parameter int MAX_FILES = 32
) (
    input  wire            clk,
    input  wire            rst_n,
    fcc_item_if.sink       item,
    fcc_result_if.source   result,
    fcc_cfg_if.sink        cfg
);

    localparam int AW  = $clog2(FAT_DEPTH);
    localparam int FW  = $clog2(MAX_FILES + 1);
    localparam int FIW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam logic [12:0] FD_CAP = 13'((FAT_DEPTH < 8191) ? FAT_DEPTH : 8191);
    localparam logic [5:0]  MF_CAP = 6'((MAX_FILES < 63) ? MAX_FILES : 63);

    // Configuration registers.
    logic [10:0] block_size_reg;
    logic [5:0]  file_count_reg;
    logic [12:0] fat_count_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= 11'd1;
            file_count_reg <= 6'd0;
            fat_count_reg  <= 13'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BLOCK_SIZE: block_size_reg <= cfg.data[10:0];
                REG_FILE_COUNT: file_count_reg <= cfg.data[5:0];
                REG_FAT_COUNT:  fat_count_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // Effective counts of a run.
    logic [12:0] fc;
    logic [5:0]  nf6;
    logic [FW-1:0] nf;
    assign fc  = (fat_count_reg > FD_CAP) ? FD_CAP : fat_count_reg;
    assign nf6 = (file_count_reg > MF_CAP) ? MF_CAP : file_count_reg;
    assign nf  = FW'(nf6);

    // Control and walk registers.
    state_t           state_reg, state_next;
    logic [12:0]      cnt_reg, cnt_next;
    logic [FW-1:0]    f_reg, f_next;
    logic signed [12:0] cur_reg, cur_next;
    logic             first_reg, first_next;
    logic [12:0]      len_reg, len_next;
    logic [12:0]      owned_reg, owned_next;
    logic [30:0]      size_reg, size_next;
    logic [23:0]      prod_reg, prod_next;
    logic [3:0]       flags_reg [MAX_FILES];

    // Output register.
    logic        ov_reg, ov_next;
    logic [4:0]  o_idx_reg, o_idx_next;
    logic [3:0]  o_flags_reg, o_flags_next;
    logic [12:0] o_free_reg, o_free_next;
    logic        o_summ_reg, o_summ_next;

    assign item.ready = (state_reg == ST_IDLE);
    wire item_acc = item.valid && item.ready;

    // Allocation table memory.
    logic [12:0] fat_mem [FAT_DEPTH];
    logic [12:0] fat_q;
    logic        mem_rd;
    logic [AW-1:0] rd_addr;
    assign mem_rd  = (state_reg == ST_ISSUE);
    assign rd_addr = AW'(cur_reg[11:0]);

    always_ff @(posedge clk)
    begin
        if (item_acc && item.kind == KIND_LOAD_FAT && 32'(item.entry_index) < FAT_DEPTH)
            fat_mem[AW'(item.entry_index)] <= item.next_block;
        if (mem_rd)
            fat_q <= fat_mem[rd_addr];
    end

    // Owner and visit tag memory, one word per block: {owner, tag}.
    logic [2*FW-1:0] tag_mem [FAT_DEPTH];
    logic [2*FW-1:0] tag_q;
    logic            tag_we;
    logic [AW-1:0]   tag_waddr;
    logic [2*FW-1:0] tag_wd;

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_waddr] <= tag_wd;
        if (mem_rd)
            tag_q <= tag_mem[rd_addr];
    end

    // Directory memory.
    dir_entry_t dir_mem [MAX_FILES];
    dir_entry_t dir_q;

    always_ff @(posedge clk)
    begin
        if (item_acc && item.kind == KIND_LOAD_DIR && 32'(item.entry_index) < MAX_FILES)
            dir_mem[FIW'(item.entry_index)] <= '{first: item.first_block,
                                                 size: item.file_size};
        if (state_reg == ST_DIR_RD)
            dir_q <= dir_mem[f_reg[FIW-1:0]];
    end

    // Walk decode.
    logic [FW-1:0] me, own, vt;
    logic head_ok, next_ok, self_loop, seen;
    assign me        = f_reg + FW'(1);
    assign own       = tag_q[2*FW-1:FW];
    assign vt        = tag_q[FW-1:0];
    assign head_ok   = !dir_q.first[12] && {1'b0, dir_q.first[11:0]} < fc;
    assign next_ok   = !fat_q[12] && {1'b0, fat_q[11:0]} < fc;
    assign self_loop = first_reg && (fat_q == cur_reg);
    assign seen      = !first_reg && (vt == me);

    // Flag updates of the current cycle.
    logic [3:0] set_me;
    logic       set_other;
    logic [31:0] lim;
    assign lim = 32'(size_reg) + 32'(block_size_reg);

    always_comb
    begin
        set_me    = 4'b0000;
        set_other = 1'b0;
        if (state_reg == ST_HEAD)
        begin
            if (!head_ok && dir_q.size != 31'd0)
                set_me[0] = 1'b1;
            if (head_ok && dir_q.size == 31'd0)
                set_me[1] = 1'b1;
        end
        if (state_reg == ST_VISIT)
        begin
            if (own != '0 && own != me)
            begin
                set_me[3] = 1'b1;
                set_other = 1'b1;
            end
            if (self_loop || seen)
                set_me[2] = 1'b1;
        end
        if (state_reg == ST_CMP)
        begin
            if (32'(prod_reg) >= lim)
                set_me[1] = 1'b1;
            else if (32'(prod_reg) < 32'(size_reg))
                set_me[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FILES; i++)
                flags_reg[i] <= 4'b0000;
        end
        else if (item_acc && item.kind == KIND_RUN)
        begin
            for (int i = 0; i < MAX_FILES; i++)
                flags_reg[i] <= 4'b0000;
        end
        else
        begin
            flags_reg[f_reg[FIW-1:0]] <= flags_reg[f_reg[FIW-1:0]] | set_me;
            if (set_other)
                flags_reg[FIW'(own - FW'(1))] <= flags_reg[FIW'(own - FW'(1))] | 4'b1000;
        end
    end

    // Main sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        f_next       = f_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        len_next     = len_reg;
        owned_next   = owned_reg;
        size_next    = size_reg;
        prod_next    = prod_reg;
        tag_we       = 1'b0;
        tag_waddr    = rd_addr;
        tag_wd       = tag_q;
        ov_next      = ov_reg;
        o_idx_next   = o_idx_reg;
        o_flags_next = o_flags_reg;
        o_free_next  = o_free_reg;
        o_summ_next  = o_summ_reg;

        if (ov_reg && result.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && item.kind == KIND_RUN)
                begin
                    cnt_next   = 13'd0;
                    f_next     = '0;
                    owned_next = 13'd0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (cnt_reg < fc)
                begin
                    tag_we    = 1'b1;
                    tag_waddr = AW'(cnt_reg);
                    tag_wd    = '0;
                    cnt_next  = cnt_reg + 13'd1;
                end
                else if (nf == '0)
                    state_next = ST_EMIT;
                else
                    state_next = ST_DIR_RD;
            end
            ST_DIR_RD:
                state_next = ST_HEAD;
            ST_HEAD:
            begin
                size_next  = dir_q.size;
                cur_next   = dir_q.first;
                first_next = 1'b1;
                len_next   = 13'd0;
                state_next = head_ok ? ST_ISSUE : ST_DIR_RD;
                if (!head_ok)
                begin
                    f_next = f_reg + FW'(1);
                    if (f_next == nf)
                    begin
                        f_next     = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ISSUE:
                state_next = ST_VISIT;
            ST_VISIT:
            begin
                // Touch the block, then either stop on a cycle or follow the chain.
                tag_we = 1'b1;
                tag_wd = {(own == '0) ? me : own, vt};
                if (own == '0)
                    owned_next = owned_reg + 13'd1;
                if (self_loop)
                begin
                    f_next     = f_reg + FW'(1);
                    state_next = ST_DIR_RD;
                    if (f_next == nf)
                    begin
                        f_next     = '0;
                        state_next = ST_EMIT;
                    end
                end
                else if (seen)
                    state_next = ST_MUL;
                else
                begin
                    tag_wd     = {(own == '0) ? me : own, me};
                    len_next   = len_reg + 13'd1;
                    first_next = 1'b0;
                    cur_next   = fat_q;
                    state_next = next_ok ? ST_ISSUE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = 24'(block_size_reg) * 24'(len_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                f_next     = f_reg + FW'(1);
                state_next = ST_DIR_RD;
                if (f_next == nf)
                begin
                    f_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || result.ready)
                begin
                    ov_next = 1'b1;
                    if (f_reg < nf)
                    begin
                        o_idx_next   = 5'(f_reg);
                        o_flags_next = flags_reg[f_reg[FIW-1:0]];
                        o_free_next  = 13'd0;
                        o_summ_next  = 1'b0;
                        f_next       = f_reg + FW'(1);
                    end
                    else
                    begin
                        o_idx_next   = 5'd0;
                        o_flags_next = 4'b0000;
                        o_free_next  = fc - owned_reg;
                        o_summ_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= 13'd0;
            f_reg     <= '0;
            first_reg <= 1'b0;
            len_reg   <= 13'd0;
            owned_reg <= 13'd0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            f_reg     <= f_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            owned_reg <= owned_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        size_reg    <= size_next;
        prod_reg    <= prod_next;
        o_idx_reg   <= o_idx_next;
        o_flags_reg <= o_flags_next;
        o_free_reg  <= o_free_next;
        o_summ_reg  <= o_summ_next;
    end

    assign result.valid         = ov_reg;
    assign result.file_index    = o_idx_reg;
    assign result.too_few       = o_flags_reg[0];
    assign result.too_many      = o_flags_reg[1];
    assign result.has_cycle     = o_flags_reg[2];
    assign result.shares_blocks = o_flags_reg[3];
    assign result.free_blocks   = o_free_reg;
    assign result.is_summary    = o_summ_reg;
    assign result.last          = o_summ_reg;

endmodule
`default_nettype wire
